// File: hdl/kv_get_response_parser_defines.svh
// Assertion macros shared by the parser RTL.
`ifndef KV_GET_RESPONSE_PARSER_DEFINES_SVH
`define KV_GET_RESPONSE_PARSER_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define KV_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/kvgrp_pkg.sv
// Types and constants of the key-value get response parser.
`default_nettype none
package kvgrp_pkg;

    localparam int unsigned MAX_VERSION_WIDTH = 8;
    localparam int unsigned OUT_DEPTH         = 3;

    typedef enum logic [3:0] {
        PH_STATUS  = 4'd0,
        PH_ERRLEN  = 4'd1,
        PH_ERRBYTE = 4'd2,
        PH_COUNT   = 4'd3,
        PH_VALSIZE = 4'd4,
        PH_ENTRIES = 4'd5,
        PH_VWIDTH  = 4'd6,
        PH_NODE    = 4'd7,
        PH_VERSION = 4'd8,
        PH_TSTAMP  = 4'd9,
        PH_VALBYTE = 4'd10
    } t_phase;

    typedef enum logic [3:0] {
        KIND_STATUS    = 4'd0,
        KIND_ERRLEN    = 4'd1,
        KIND_ERRBYTE   = 4'd2,
        KIND_COUNT     = 4'd3,
        KIND_VALSIZE   = 4'd4,
        KIND_ENTRIES   = 4'd5,
        KIND_VWIDTH    = 4'd6,
        KIND_NODE      = 4'd7,
        KIND_VERSION   = 4'd8,
        KIND_TIMESTAMP = 4'd9,
        KIND_VALBYTE   = 4'd10,
        KIND_BADWIDTH  = 4'd11
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] value;
        logic        eor;
    } t_item;

endpackage
`default_nettype wire

// File: hdl/kv_get_response_parser.sv
// An item completed by an accepted byte is registered into the output queue,
// behind any items already waiting. Throughput: one byte per cycle; a byte that
// yields two items queues both, and input stalls while two or more items wait
// in the three-entry output queue.
// Reset (synchronous, active low): parser expects a status field, queue empties.
`default_nettype none
`include "kv_get_response_parser_defines.svh"
module kv_get_response_parser (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_in_byte,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output kvgrp_pkg::t_kind          o_item_kind,
    output logic [63:0]               o_item_value,
    output logic                      o_end_of_response
);
    import kvgrp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [63:0] r_field_shift, n_field_shift;
    logic [3:0]  r_field_bytes_left, n_field_bytes_left;
    logic [31:0] r_results_left, n_results_left;
    logic [15:0] r_entries_left, n_entries_left;
    logic [3:0]  r_version_width, n_version_width;
    logic [31:0] r_value_size_held, n_value_size_held;
    logic [31:0] r_clock_bytes, n_clock_bytes;
    logic [31:0] r_payload_left, n_payload_left;

    t_item       r_q [OUT_DEPTH];
    t_item       n_q [OUT_DEPTH];
    logic [1:0]  r_count, n_count;

    t_item       it0, it1;
    logic [1:0]  n_push;
    logic        in_acc, pop;

    assign o_in_ready        = !r_count[1];
    assign in_acc            = i_in_valid && o_in_ready;
    assign o_out_valid       = (r_count != 2'd0);
    assign pop               = o_out_valid && i_out_ready;
    assign o_item_kind       = r_q[0].kind;
    assign o_item_value      = r_q[0].value;
    assign o_end_of_response = r_q[0].eor;

    // Parser: next state and up to two items per accepted beat.
    always_comb begin
        logic [63:0] v;
        logic [31:0] pl_dec;
        logic [31:0] rl_dec;
        logic [15:0] el_dec;
        logic [31:0] cb_ts;
        logic [31:0] pl_ts;

        v      = {r_field_shift[55:0], i_in_byte};
        pl_dec = r_payload_left - 32'd1;
        rl_dec = r_results_left - 32'd1;
        el_dec = r_entries_left - 16'd1;
        cb_ts  = r_clock_bytes + 32'd8;
        pl_ts  = (r_value_size_held > cb_ts) ? (r_value_size_held - cb_ts) : 32'd0;

        n_phase            = r_phase;
        n_field_shift      = r_field_shift;
        n_field_bytes_left = r_field_bytes_left;
        n_results_left     = r_results_left;
        n_entries_left     = r_entries_left;
        n_version_width    = r_version_width;
        n_value_size_held  = r_value_size_held;
        n_clock_bytes      = r_clock_bytes;
        n_payload_left     = r_payload_left;
        it0                = '{kind: KIND_STATUS, value: 64'd0, eor: 1'b0};
        it1                = '{kind: KIND_STATUS, value: 64'd0, eor: 1'b0};
        n_push             = 2'd0;

        if (in_acc) begin
            unique case (r_phase)
                PH_ERRBYTE: begin
                    n_payload_left = pl_dec;
                    n_push = 2'd1;
                    it0 = '{kind: KIND_ERRBYTE, value: {56'd0, i_in_byte},
                            eor: (pl_dec == 32'd0)};
                    if (pl_dec == 32'd0) begin
                        n_phase            = PH_STATUS;
                        n_field_bytes_left = 4'd2;
                        n_field_shift      = 64'd0;
                    end
                end
                PH_VALBYTE: begin
                    n_payload_left = pl_dec;
                    n_push = 2'd1;
                    it0 = '{kind: KIND_VALBYTE, value: {56'd0, i_in_byte}, eor: 1'b0};
                    if (pl_dec == 32'd0) begin
                        n_results_left = rl_dec;
                        n_field_shift  = 64'd0;
                        if (rl_dec == 32'd0) begin
                            it0.eor            = 1'b1;
                            n_phase            = PH_STATUS;
                            n_field_bytes_left = 4'd2;
                        end else begin
                            n_phase            = PH_VALSIZE;
                            n_field_bytes_left = 4'd4;
                        end
                    end
                end
                PH_STATUS, PH_ERRLEN, PH_COUNT, PH_VALSIZE, PH_ENTRIES,
                PH_VWIDTH, PH_NODE, PH_VERSION, PH_TSTAMP: begin
                    n_field_shift = v;
                    if (r_field_bytes_left > 4'd1) begin
                        n_field_bytes_left = r_field_bytes_left - 4'd1;
                    end else begin
                        n_field_bytes_left = 4'd0;
                        n_push = 2'd1;
                        unique case (r_phase)
                            PH_STATUS: begin
                                it0 = '{kind: KIND_STATUS, value: {48'd0, v[15:0]},
                                        eor: 1'b0};
                                n_field_shift = 64'd0;
                                if (v[15:0] != 16'd0) begin
                                    n_phase            = PH_ERRLEN;
                                    n_field_bytes_left = 4'd2;
                                end else begin
                                    n_phase            = PH_COUNT;
                                    n_field_bytes_left = 4'd4;
                                end
                            end
                            PH_ERRLEN: begin
                                it0 = '{kind: KIND_ERRLEN, value: {48'd0, v[15:0]},
                                        eor: (v[15:0] == 16'd0)};
                                if (v[15:0] == 16'd0) begin
                                    n_phase            = PH_STATUS;
                                    n_field_bytes_left = 4'd2;
                                    n_field_shift      = 64'd0;
                                end else begin
                                    n_payload_left = {16'd0, v[15:0]};
                                    n_phase        = PH_ERRBYTE;
                                end
                            end
                            PH_COUNT: begin
                                n_results_left = v[31:0];
                                n_field_shift  = 64'd0;
                                it0 = '{kind: KIND_COUNT, value: {32'd0, v[31:0]},
                                        eor: (v[31:0] == 32'd0)};
                                if (v[31:0] == 32'd0) begin
                                    n_phase            = PH_STATUS;
                                    n_field_bytes_left = 4'd2;
                                end else begin
                                    n_phase            = PH_VALSIZE;
                                    n_field_bytes_left = 4'd4;
                                end
                            end
                            PH_VALSIZE: begin
                                n_value_size_held  = v[31:0];
                                n_clock_bytes      = 32'd0;
                                n_phase            = PH_ENTRIES;
                                n_field_bytes_left = 4'd2;
                                n_field_shift      = 64'd0;
                                it0 = '{kind: KIND_VALSIZE, value: {32'd0, v[31:0]},
                                        eor: 1'b0};
                            end
                            PH_ENTRIES: begin
                                n_entries_left     = v[15:0];
                                n_clock_bytes      = 32'd2;
                                n_phase            = PH_VWIDTH;
                                n_field_bytes_left = 4'd1;
                                n_field_shift      = 64'd0;
                                it0 = '{kind: KIND_ENTRIES, value: {48'd0, v[15:0]},
                                        eor: 1'b0};
                            end
                            PH_VWIDTH: begin
                                n_clock_bytes = r_clock_bytes + 32'd1;
                                n_field_shift = 64'd0;
                                it0 = '{kind: KIND_VWIDTH, value: {56'd0, v[7:0]},
                                        eor: 1'b0};
                                if (v[7:0] > 8'(MAX_VERSION_WIDTH)) begin
                                    n_push = 2'd2;
                                    it1 = '{kind: KIND_BADWIDTH, value: {56'd0, v[7:0]},
                                            eor: 1'b1};
                                    n_phase            = PH_STATUS;
                                    n_field_bytes_left = 4'd2;
                                end else begin
                                    n_version_width = v[3:0];
                                    if (r_entries_left != 16'd0) begin
                                        n_phase            = PH_NODE;
                                        n_field_bytes_left = 4'd2;
                                    end else begin
                                        n_phase            = PH_TSTAMP;
                                        n_field_bytes_left = 4'd8;
                                    end
                                end
                            end
                            PH_NODE: begin
                                n_clock_bytes = r_clock_bytes + 32'd2;
                                n_field_shift = 64'd0;
                                it0 = '{kind: KIND_NODE, value: {48'd0, v[15:0]},
                                        eor: 1'b0};
                                if (r_version_width == 4'd0) begin
                                    // zero-width version: emit it now, close the entry
                                    n_push = 2'd2;
                                    it1 = '{kind: KIND_VERSION, value: 64'd0, eor: 1'b0};
                                    n_entries_left = el_dec;
                                    if (el_dec != 16'd0) begin
                                        n_phase            = PH_NODE;
                                        n_field_bytes_left = 4'd2;
                                    end else begin
                                        n_phase            = PH_TSTAMP;
                                        n_field_bytes_left = 4'd8;
                                    end
                                end else begin
                                    n_phase            = PH_VERSION;
                                    n_field_bytes_left = r_version_width;
                                end
                            end
                            PH_VERSION: begin
                                n_clock_bytes  = r_clock_bytes + {28'd0, r_version_width};
                                n_field_shift  = 64'd0;
                                n_entries_left = el_dec;
                                it0 = '{kind: KIND_VERSION, value: v, eor: 1'b0};
                                if (el_dec != 16'd0) begin
                                    n_phase            = PH_NODE;
                                    n_field_bytes_left = 4'd2;
                                end else begin
                                    n_phase            = PH_TSTAMP;
                                    n_field_bytes_left = 4'd8;
                                end
                            end
                            default: begin
                                n_clock_bytes  = cb_ts;
                                n_payload_left = pl_ts;
                                it0 = '{kind: KIND_TIMESTAMP, value: v, eor: 1'b0};
                                if (pl_ts != 32'd0) begin
                                    n_phase = PH_VALBYTE;
                                end else begin
                                    // no value bytes: the timestamp closes the result
                                    n_results_left = rl_dec;
                                    n_field_shift  = 64'd0;
                                    if (rl_dec == 32'd0) begin
                                        it0.eor            = 1'b1;
                                        n_phase            = PH_STATUS;
                                        n_field_bytes_left = 4'd2;
                                    end else begin
                                        n_phase            = PH_VALSIZE;
                                        n_field_bytes_left = 4'd4;
                                    end
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    // unknown phase code: drop the beat and restart
                    n_phase            = PH_STATUS;
                    n_field_bytes_left = 4'd2;
                    n_field_shift      = 64'd0;
                    n_results_left     = 32'd0;
                    n_entries_left     = 16'd0;
                    n_version_width    = 4'd0;
                    n_value_size_held  = 32'd0;
                    n_clock_bytes      = 32'd0;
                    n_payload_left     = 32'd0;
                end
            endcase
        end
    end

    // Output queue: advance on a taken beat, append new items behind the rest.
    always_comb begin
        logic [1:0] base;
        logic [2:0] src;
        logic [2:0] idx;

        base    = r_count - {1'b0, pop};
        n_count = base + n_push;
        for (int j = 0; j < OUT_DEPTH; j++) begin
            src = 3'(j) + {2'b00, pop};
            idx = 3'(j) - {1'b0, base};
            if (src < {1'b0, r_count}) begin
                n_q[j] = r_q[src[1:0]];
            end else if (idx == 3'd0 && n_push != 2'd0) begin
                n_q[j] = it0;
            end else if (idx == 3'd1 && n_push == 2'd2) begin
                n_q[j] = it1;
            end else begin
                n_q[j] = r_q[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= PH_STATUS;
            r_field_shift      <= 64'd0;
            r_field_bytes_left <= 4'd2;
            r_results_left     <= 32'd0;
            r_entries_left     <= 16'd0;
            r_version_width    <= 4'd0;
            r_value_size_held  <= 32'd0;
            r_clock_bytes      <= 32'd0;
            r_payload_left     <= 32'd0;
            r_count            <= 2'd0;
        end else begin
            r_phase            <= n_phase;
            r_field_shift      <= n_field_shift;
            r_field_bytes_left <= n_field_bytes_left;
            r_results_left     <= n_results_left;
            r_entries_left     <= n_entries_left;
            r_version_width    <= n_version_width;
            r_value_size_held  <= n_value_size_held;
            r_clock_bytes      <= n_clock_bytes;
            r_payload_left     <= n_payload_left;
            r_count            <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    `KV_ASSERT_ALWAYS(a_payload_nonzero, (!(r_phase == PH_ERRBYTE || r_phase == PH_VALBYTE) || (r_payload_left != 32'd0)), "payload phase with zero bytes left")

    `KV_ASSERT_NEXT(a_valbyte_one_item, (in_acc && r_phase == PH_VALBYTE), (r_count == 2'($past(r_count) + 2'd1 - {1'b0, $past(pop)})), "value byte did not queue exactly one item")

    `KV_ASSERT_NEXT(a_first_status_byte_silent, (in_acc && r_phase == PH_STATUS && r_field_bytes_left == 4'd2), (r_count == 2'($past(r_count) - {1'b0, $past(pop)})), "first status byte queued an item")

endmodule
`default_nettype wire
